@@ rtl/icmp_erm_pkg.sv @@
// Shared types and constants for the ICMP echo reply matcher.
package icmp_erm_pkg;

  // Byte position counter width; the counter saturates at its maximum.
  localparam int unsigned POS_W = 7;
  localparam logic [POS_W-1:0] POS_MAX = '1;

  // IPv4 header offsets relative to the start of the IPv4 header.
  localparam int unsigned IP_PROTO_OFFSET    = 9;
  localparam int unsigned IP_SRC_OFFSET      = 12;
  localparam int unsigned IP_SRC_LAST_OFFSET = 15;

  localparam logic [7:0] PROTO_ICMP      = 8'd1;
  localparam logic [7:0] TYPE_ECHO_REPLY = 8'd0;

  // Verdict codes.
  localparam logic [2:0] VERDICT_NOT_ICMP     = 3'd0;
  localparam logic [2:0] VERDICT_OTHER_SOURCE = 3'd1;
  localparam logic [2:0] VERDICT_OTHER_TYPE   = 3'd2;
  localparam logic [2:0] VERDICT_ECHO_REPLY   = 3'd3;
  localparam logic [2:0] VERDICT_TRUNCATED    = 3'd4;

  typedef struct packed {
    logic [2:0] verdict;
    logic       reply_seen;
    logic [7:0] icmp_type;
  } result_t;

endpackage

@@ rtl/icmp_erm_out_buf.sv @@
// Two-entry result buffer: an output register backed by a skid register.
module icmp_erm_out_buf (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  icmp_erm_pkg::result_t push_data,
  output logic                  full,
  output logic                  out_valid,
  input  logic                  out_stall,
  output icmp_erm_pkg::result_t out_data
);
  import icmp_erm_pkg::*;

  logic    main_valid;
  logic    skid_valid;
  result_t main_data;
  result_t skid_data;
  logic    main_load;

  // The main register can take new data when it is empty or being drained.
  assign main_load = !main_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (main_load) begin
      main_valid <= skid_valid || push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (main_load) begin
      main_data <= skid_valid ? skid_data : push_data;
    end
    if (!main_load && push) begin
      skid_data <= push_data;
    end
  end

  assign full      = skid_valid;
  assign out_valid = main_valid;
  assign out_data  = main_data;

endmodule

@@ rtl/icmp_echo_reply_matcher.sv @@
// Top level of the ICMP echo reply matcher.
// The result of a frame is pushed into the output buffer when its last byte is accepted.
// Throughput: one item per cycle while in_stall is low; the per-byte parse and the verdict are combinational.
// A two-entry output buffer lets the input keep running while one result waits to be taken.
// Reset (rst, synchronous, active high) clears the frame state, sets target_address to zero
// and empties the output buffer.
module icmp_echo_reply_matcher #(
  parameter int unsigned LINK_HEADER_BYTES = 14
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration: target host address, first wire byte most significant.
  input  logic        cfg_write,
  input  logic [31:0] cfg_data,
  // Input channel: one frame byte per item.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  frame_byte,
  input  logic        last_byte,
  // Output channel: one verdict per frame.
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  verdict,
  output logic        reply_seen,
  output logic [7:0]  icmp_type
);
  import icmp_erm_pkg::*;

  // Absolute byte positions of the fields used, all below the saturation point.
  localparam logic [POS_W-1:0] POS_HDR      = POS_W'(LINK_HEADER_BYTES);
  localparam logic [POS_W-1:0] POS_PROTO    = POS_W'(LINK_HEADER_BYTES + IP_PROTO_OFFSET);
  localparam logic [POS_W-1:0] POS_SRC      = POS_W'(LINK_HEADER_BYTES + IP_SRC_OFFSET);
  localparam logic [POS_W-1:0] POS_SRC_LAST = POS_W'(LINK_HEADER_BYTES + IP_SRC_LAST_OFFSET);

  // Configuration register.
  logic [31:0] target_address;

  // Per-frame state. byte_position is the index of the next byte to arrive.
  logic [POS_W-1:0] byte_position;
  logic [3:0]       header_words;
  logic [7:0]       protocol_byte;
  logic             source_equal;
  logic [7:0]       type_byte;
  logic             type_captured;

  // Values after the current byte has been applied. A field that lands on the
  // current byte is visible to the verdict of that same byte.
  logic [3:0]       header_words_next;
  logic [7:0]       protocol_byte_next;
  logic             source_equal_next;
  logic [7:0]       type_byte_next;
  logic             type_captured_next;
  logic [POS_W-1:0] byte_position_next;

  logic [POS_W-1:0] type_pos;
  logic [POS_W-1:0] src_off;
  logic [7:0]       want_byte;
  logic             accept;
  result_t          result;

  assign accept = in_valid && !in_stall;

  always_comb begin
    // The header length nibble sits in the first IPv4 byte.
    header_words_next = (byte_position == POS_HDR) ? frame_byte[3:0] : header_words;

    protocol_byte_next = (byte_position == POS_PROTO) ? frame_byte : protocol_byte;

    // Source address bytes are compared one at a time against the target
    // value current when each byte arrives.
    src_off = byte_position - POS_SRC;
    unique case (src_off[1:0])
      2'd0:    want_byte = target_address[31:24];
      2'd1:    want_byte = target_address[23:16];
      2'd2:    want_byte = target_address[15:8];
      default: want_byte = target_address[7:0];
    endcase
    source_equal_next = source_equal;
    if (byte_position >= POS_SRC && byte_position <= POS_SRC_LAST &&
        want_byte != frame_byte) begin
      source_equal_next = 1'b0;
    end

    // The ICMP type follows the IPv4 header; a short header length puts it
    // inside the header, and a length of zero makes it the first IPv4 byte.
    type_pos = POS_HDR + POS_W'({header_words_next, 2'b00});
    type_byte_next     = type_byte;
    type_captured_next = type_captured;
    if (!type_captured && byte_position >= POS_HDR && byte_position == type_pos) begin
      type_byte_next     = frame_byte;
      type_captured_next = 1'b1;
    end

    byte_position_next = (byte_position == POS_MAX) ? byte_position
                                                    : byte_position + 1'b1;
  end

  // Verdict for a frame ending on this byte; checks run in priority order.
  always_comb begin
    priority if (byte_position < POS_PROTO) begin
      result.verdict = VERDICT_TRUNCATED;
    end else if (protocol_byte_next != PROTO_ICMP) begin
      result.verdict = VERDICT_NOT_ICMP;
    end else if (byte_position < POS_SRC_LAST) begin
      result.verdict = VERDICT_TRUNCATED;
    end else if (!source_equal_next) begin
      result.verdict = VERDICT_OTHER_SOURCE;
    end else if (!type_captured_next) begin
      result.verdict = VERDICT_TRUNCATED;
    end else if (type_byte_next != TYPE_ECHO_REPLY) begin
      result.verdict = VERDICT_OTHER_TYPE;
    end else begin
      result.verdict = VERDICT_ECHO_REPLY;
    end
    result.reply_seen = (result.verdict == VERDICT_ECHO_REPLY);
    result.icmp_type  = type_captured_next ? type_byte_next : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_address <= '0;
    end else if (cfg_write) begin
      target_address <= cfg_data;
    end
  end

  // Frame state: updated on every accepted byte and cleared after the last one.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      header_words  <= '0;
      protocol_byte <= '0;
      source_equal  <= 1'b1;
      type_byte     <= '0;
      type_captured <= 1'b0;
    end else if (accept) begin
      if (last_byte) begin
        byte_position <= '0;
        header_words  <= '0;
        protocol_byte <= '0;
        source_equal  <= 1'b1;
        type_byte     <= '0;
        type_captured <= 1'b0;
      end else begin
        byte_position <= byte_position_next;
        header_words  <= header_words_next;
        protocol_byte <= protocol_byte_next;
        source_equal  <= source_equal_next;
        type_byte     <= type_byte_next;
        type_captured <= type_captured_next;
      end
    end
  end

  // The input stalls only when both the output register and the skid entry
  // hold results that have not been taken.
  result_t out_data;

  icmp_erm_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && last_byte),
    .push_data (result),
    .full      (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign verdict    = out_data.verdict;
  assign reply_seen = out_data.reply_seen;
  assign icmp_type  = out_data.icmp_type;

endmodule

@@ rtl/icmp_erm_checker.sv @@
// Port-level checks for the ICMP echo reply matcher, bound to the top level.
module icmp_erm_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        last_byte,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  verdict,
  input logic        reply_seen,
  input logic [7:0]  icmp_type
);
  import icmp_erm_pkg::*;

  // reply_seen flags exactly the echo reply verdict.
  a_reply_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (reply_seen == (verdict == VERDICT_ECHO_REPLY)))
    else $error("reply_seen does not match verdict");

  // An echo reply always carries the echo reply type byte.
  a_reply_type: assert property (@(posedge clk) disable iff (rst)
    (out_valid && verdict == VERDICT_ECHO_REPLY) |-> (icmp_type == TYPE_ECHO_REPLY))
    else $error("echo reply with nonzero type");

  // A result only appears from idle right after a last byte was accepted.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall && last_byte))
    else $error("result without a final byte");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(verdict) && $stable(icmp_type)))
    else $error("stalled result changed");

endmodule

bind icmp_echo_reply_matcher icmp_erm_checker u_icmp_erm_checker (.*);
